// File: rtl/multichannel_input_debouncer_top_defines.svh
// Assertion macros used by the checker that is bound into the debouncer.
`ifndef MULTICHANNEL_INPUT_DEBOUNCER_TOP_DEFINES_SVH
`define MULTICHANNEL_INPUT_DEBOUNCER_TOP_DEFINES_SVH

// Checked at every edge, reset included.
`define MID_ASSERT_ALWAYS(label, clock, expr) \
    label: assert property (@(posedge clock) (expr)) \
        else $error("assertion failed: label");

// Same-cycle implication, ignored while reset is asserted.
`define MID_ASSERT_IMPLY(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, ignored while reset is asserted.
`define MID_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: rtl/mid_pkg.sv
`default_nettype none

package mid_pkg;

    // Bank size and timer width.
    localparam int CHANNELS   = 32;
    localparam int TIMER_BITS = 16;

    // Fixed field widths.
    localparam int OP_BITS     = 2;
    localparam int CHAN_BITS   = 5;
    localparam int SETTLE_BITS = 16;
    localparam int MASK_BITS   = 32;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    // Bits needed to address one channel of the bank.
    localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Width at which the elapsed count is compared with the threshold.
    localparam int CMP_BITS = (TIMER_BITS > SETTLE_BITS) ? TIMER_BITS : SETTLE_BITS;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_TICKS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_MASK  = 1'd1;

    // Register reset values.
    localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 16'd100;
    localparam logic [MASK_BITS-1:0]   INVERT_RESET = 32'd0;

    // True when a channel number addresses a channel that exists.
    function automatic logic chan_in_range(input logic [CHAN_BITS-1:0] ch);
        return {1'b0, ch} < (CHAN_BITS + 1)'(CHANNELS);
    endfunction

endpackage

`default_nettype wire

// File: rtl/multichannel_input_debouncer_top.sv
`default_nettype none

// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------
// input    | in_valid / in_ready      | op, channel, raw_level
// result   | out_valid / out_ready    | debounced_level, out_channel
// config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Every item is handled in the cycle in which it is accepted: the channel state updates at
// that edge and an in-range sample's result lands in the output register (or the skid register
// while a result stalls), so one item a cycle is sustained whenever results are taken.
// A skid register behind the output register lets one more item in while a result stalls;
// in_ready falls only when both hold a result. cfg_ready is always high.
// rst_n is asynchronous and active low; it clears all channel state, restores the register
// reset values and empties the output and skid registers.

module multichannel_input_debouncer_top
    import mid_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [OP_BITS-1:0]       op,
    input  wire logic [CHAN_BITS-1:0]     channel,
    input  wire logic                     raw_level,

    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          debounced_level,
    output logic [CHAN_BITS-1:0]          out_channel,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Configuration registers.
    logic [SETTLE_BITS-1:0] settle_ticks_reg;
    logic [MASK_BITS-1:0]   invert_mask_reg;

    // Per-channel state, held in flip-flops so that a tick can advance every timer at once.
    logic [CHANNELS-1:0]   stable_reg;
    logic [CHANNELS-1:0]   stable_next;
    logic [CHANNELS-1:0]   running_reg;
    logic [CHANNELS-1:0]   running_next;
    logic [TIMER_BITS-1:0] elapsed_reg  [CHANNELS];
    logic [TIMER_BITS-1:0] elapsed_next [CHANNELS];

    // Output register and the skid register behind it.
    logic                 out_valid_reg;
    logic                 out_level_reg;
    logic [CHAN_BITS-1:0] out_chan_reg;
    logic                 skid_valid_reg;
    logic                 skid_level_reg;
    logic [CHAN_BITS-1:0] skid_chan_reg;

    logic                   accept;
    logic                   in_range;
    logic [CH_IDX_BITS-1:0] ch_idx;
    logic                   level;
    logic                   res_valid;
    logic                   res_level;
    logic                   out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign in_range  = chan_in_range(channel);
    assign ch_idx    = channel[CH_IDX_BITS-1:0];

    // The sampled level after the channel's optional inversion.
    assign level = raw_level ^ invert_mask_reg[channel];

    always_comb
    begin
        stable_next  = stable_reg;
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        res_valid    = 1'b0;
        res_level    = 1'b0;

        if (accept) begin
            case (op)
                OP_TICK:
                begin
                    // Every running timer advances and sticks at its all-ones value.
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (running_reg[i] && !(&elapsed_reg[i])) begin
                            elapsed_next[i] = elapsed_reg[i] + TIMER_BITS'(1);
                        end
                    end
                end
                OP_SAMPLE:
                begin
                    if (in_range) begin
                        if (level != stable_reg[ch_idx]) begin
                            if (running_reg[ch_idx]) begin
                                // Accept the new level once the timer has passed the threshold.
                                if (CMP_BITS'(elapsed_reg[ch_idx]) >
                                    CMP_BITS'(settle_ticks_reg)) begin
                                    stable_next[ch_idx]  = level;
                                    running_next[ch_idx] = 1'b0;
                                end
                            end else begin
                                // First sight of a change: start the settle timer.
                                running_next[ch_idx] = 1'b1;
                                elapsed_next[ch_idx] = '0;
                            end
                        end else begin
                            running_next[ch_idx] = 1'b0;
                        end
                        res_valid = 1'b1;
                        res_level = stable_next[ch_idx];
                    end
                end
                OP_CLEAR:
                begin
                    // Only the stable level is cleared; the timer carries on as it was.
                    if (in_range) begin
                        stable_next[ch_idx] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stable_reg  <= '0;
            running_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                elapsed_reg[i] <= '0;
            end
        end else begin
            stable_reg  <= stable_next;
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            settle_ticks_reg <= SETTLE_RESET;
            invert_mask_reg  <= INVERT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SETTLE_TICKS: settle_ticks_reg <= cfg_data[SETTLE_BITS-1:0];
                REG_INVERT_MASK:  invert_mask_reg  <= cfg_data[MASK_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The output register takes the skid entry first, so results leave in order. A new
    // result can only arrive while the skid register is empty.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_level_reg <= skid_level_reg;
                out_chan_reg  <= skid_chan_reg;
            end else begin
                out_level_reg <= res_level;
                out_chan_reg  <= channel;
            end
        end else if (res_valid) begin
            skid_level_reg <= res_level;
            skid_chan_reg  <= channel;
        end
    end

    assign out_valid       = out_valid_reg;
    assign debounced_level = out_level_reg;
    assign out_channel     = out_chan_reg;

endmodule

`default_nettype wire

// File: rtl/mid_checker.sv
`default_nettype none

`include "multichannel_input_debouncer_top_defines.svh"

module mid_checker
    import mid_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic [OP_BITS-1:0]   op,
    input wire logic [CHAN_BITS-1:0] channel,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic                 debounced_level,
    input wire logic [CHAN_BITS-1:0] out_channel
);

    // An edge that sees reset held leaves the block with no result and open for items.
    `MID_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid && in_ready))

    // Back-pressure only arises while a result is waiting at the output.
    `MID_ASSERT_IMPLY(a_stall_needs_result, clk, rst_n, !in_ready, out_valid)

    // A stalled result stays put.
    `MID_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(debounced_level) && $stable(out_channel))

    // A sample taken with the output empty shows its result in the next cycle.
    `MID_ASSERT_NEXT(a_sample_result, clk, rst_n, in_valid && in_ready && !out_valid && op == OP_SAMPLE && chan_in_range(channel), out_valid && out_channel == $past(channel))

    // A tick, a clear or an unused op taken with the output empty produces nothing.
    `MID_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, in_valid && in_ready && !out_valid && op != OP_SAMPLE, !out_valid)

endmodule

bind multichannel_input_debouncer_top mid_checker u_mid_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .channel         (channel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .debounced_level (debounced_level),
    .out_channel     (out_channel)
);

`default_nettype wire

// File: verif/debounce_check.sv
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the debouncer. It keeps its own
// copy of the channel state, works out the level each sample must give, and compares
// every result with the oldest level still owed.
module debounce_check
    import mid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [OP_BITS-1:0]       op,
    input  logic [CHAN_BITS-1:0]     channel,
    input  logic                     raw_level,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     debounced_level,
    input  logic [CHAN_BITS-1:0]     out_channel,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic                 level;
        logic [CHAN_BITS-1:0] chan;
    } owed_level_t;

    owed_level_t            owed_levels[$];
    logic [SETTLE_BITS-1:0] settle;
    logic [MASK_BITS-1:0]   invert;
    logic                   stable_lvl[CHANNELS];
    logic                   timer_on[CHANNELS];
    logic [TIMER_BITS-1:0]  elapsed[CHANNELS];

    // Applies one accepted item to the channel state and records the level owed.
    function automatic void debounce_step(input logic [OP_BITS-1:0] code,
                                          input logic [CHAN_BITS-1:0] ch,
                                          input logic raw);
        logic        level;
        owed_level_t owed;
        if (code == OP_TICK) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (timer_on[i] && elapsed[i] != '1) begin
                    elapsed[i] = elapsed[i] + 1'b1;
                end
            end
        end else if (code == OP_CLEAR) begin
            stable_lvl[ch] = 1'b0;
        end else if (code == OP_SAMPLE) begin
            level = raw ^ invert[ch];
            if (level != stable_lvl[ch]) begin
                if (!timer_on[ch]) begin
                    timer_on[ch] = 1'b1;
                    elapsed[ch]  = '0;
                end else if (elapsed[ch] > settle) begin
                    stable_lvl[ch] = level;
                    timer_on[ch]   = 1'b0;
                end
            end else begin
                timer_on[ch] = 1'b0;
            end
            owed.level = stable_lvl[ch];
            owed.chan  = ch;
            owed_levels.push_back(owed);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        owed_level_t owed;
        if (!rst_n) begin
            settle     = SETTLE_RESET;
            invert     = INVERT_RESET;
            fail_count = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                stable_lvl[i] = 1'b0;
                timer_on[i]   = 1'b0;
                elapsed[i]    = '0;
            end
            owed_levels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SETTLE_TICKS: settle = cfg_data[SETTLE_BITS-1:0];
                    REG_INVERT_MASK:  invert = cfg_data[MASK_BITS-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready) begin
                debounce_step(op, channel, raw_level);
            end
            if (out_valid && out_ready) begin
                if (owed_levels.size() == 0) begin
                    $display("%0t: unexpected result, channel %0d level %0b",
                             $time, out_channel, debounced_level);
                    fail_count++;
                end else begin
                    owed = owed_levels.pop_front();
                    if (debounced_level !== owed.level) begin
                        $display("%0t: debounced_level expected %0b actual %0b (channel %0d)",
                                 $time, owed.level, debounced_level, owed.chan);
                        fail_count++;
                    end
                    if (out_channel !== owed.chan) begin
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, owed.chan, out_channel);
                        fail_count++;
                    end
                end
            end
        end
        pending = owed_levels.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the debouncer. All prediction and comparison is done by the
// checker instance beside the block; this module only drives items, register writes and
// the result-side back-pressure, and then reports the outcome.
module tb;
    import mid_pkg::*;

    // The fourth operation code has no meaning and must be ignored by the block.
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    localparam int LIMIT       = 1_000_000;
    localparam int QUIET_GAP   = 4;
    localparam int DRAIN       = 20;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 240;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [OP_BITS-1:0]       op = OP_TICK;
    logic [CHAN_BITS-1:0]     channel = '0;
    logic                     raw_level = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     debounced_level;
    logic [CHAN_BITS-1:0]     out_channel;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_SETTLE_TICKS;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    int items_sent = 0;
    int src_idle_pct = 13;
    int sink_idle_pct = 53;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    multichannel_input_debouncer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .channel         (channel),
        .raw_level       (raw_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .debounced_level (debounced_level),
        .out_channel     (out_channel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    debounce_check level_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .channel         (channel),
        .raw_level       (raw_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .debounced_level (debounced_level),
        .out_channel     (out_channel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // The clock starts low, so the first rising edge comes after every process is waiting.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Every input changes just after a falling edge, so the block and the checker both see
    // settled values at the rising edge.
    task automatic offer(input logic [OP_BITS-1:0] code, input logic [CHAN_BITS-1:0] ch,
                         input logic raw);
        // Random gaps before the item; valid is dropped only while nothing is on offer.
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        op        = code;
        channel   = ch;
        raw_level = raw;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    // Registers may only change with nothing in flight. Ticks and clears owe no result, so
    // a quiet gap after the last result covers any item still being absorbed.
    task automatic settle_down();
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (QUIET_GAP) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        settle_down();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed debounce sequences: a random level on one channel, a run of up to two
    // items more than the threshold (capped at eight), mostly ticks with some unrelated samples
    // mixed in, then the same level again so that a change can be accepted. The rest is
    // unstructured noise, unused op included.
    task automatic random_items(input int count, input int tick_span);
        logic [CHAN_BITS-1:0] ch;
        logic                 raw;
        int                   stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(3) != 0)
            begin
                ch  = CHAN_BITS'($urandom_range(CHANNELS - 1));
                raw = 1'($urandom_range(1));
                offer(OP_SAMPLE, ch, raw);
                repeat ($urandom_range(tick_span + 2))
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        offer(OP_SAMPLE, CHAN_BITS'($urandom_range(CHANNELS - 1)),
                              1'($urandom_range(1)));
                    end
                    else
                    begin
                        offer(OP_TICK, CHAN_BITS'($urandom_range(CHANNELS - 1)),
                              1'($urandom_range(1)));
                    end
                end
                offer(OP_SAMPLE, ch, raw);
                if ($urandom_range(3) == 0)
                begin
                    offer(OP_CLEAR, ch, 1'($urandom_range(1)));
                end
            end
            else
            begin
                offer(OP_BITS'($urandom_range(OP_UNUSED, OP_TICK)),
                      CHAN_BITS'($urandom_range(CHANNELS - 1)), 1'($urandom_range(1)));
            end
        end
    endtask

    // Result side. Once asked, it refuses results for a long stretch while the sender keeps
    // offering samples, so the output and skid registers fill and in_ready falls.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_ready = rst_n && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: a run that stops making progress ends here.
    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [SETTLE_BITS-1:0] settle_val;
        logic [MASK_BITS-1:0]   mask_val;
        int                     tick_span;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset threshold of 100: a fresh change is held, the unused op and a clear give
        // nothing back, and a matching sample stops the timer.
        offer(OP_SAMPLE, 5'd0, 1'b0);
        offer(OP_SAMPLE, 5'd31, 1'b1);
        offer(OP_TICK, 5'd31, 1'b1);
        offer(OP_SAMPLE, 5'd31, 1'b1);
        offer(OP_UNUSED, 5'd31, 1'b1);
        offer(OP_CLEAR, 5'd5, 1'b0);
        offer(OP_SAMPLE, 5'd31, 1'b0);

        // Zero threshold with the end channels inverted. The sample that starts a timer
        // cannot accept; one tick later it can.
        write_reg(REG_SETTLE_TICKS, CFG_DATA_BITS'(0));
        write_reg(REG_INVERT_MASK, 32'h8000_0001);
        offer(OP_SAMPLE, 5'd0, 1'b0);
        offer(OP_SAMPLE, 5'd0, 1'b0);
        offer(OP_TICK, 5'd0, 1'b0);
        offer(OP_SAMPLE, 5'd0, 1'b0);
        // A clear drops the stable level but leaves a running timer alone, so the next
        // changed sample is accepted at once.
        offer(OP_SAMPLE, 5'd0, 1'b1);
        offer(OP_TICK, 5'd0, 1'b1);
        offer(OP_CLEAR, 5'd0, 1'b1);
        offer(OP_SAMPLE, 5'd0, 1'b0);
        offer(OP_SAMPLE, 5'd31, 1'b1);

        // Random phases, each with its own register settings. Idling goes light sender and
        // heavy receiver first, then the other way round, then none at all.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin settle_val = 16'd0;    mask_val = '1;        end
                1: begin settle_val = 16'd2;    mask_val = $urandom(); end
                2: begin settle_val = 16'hFFFF; mask_val = '0;        end
                3: begin settle_val = SETTLE_BITS'($urandom_range(6, 1)); mask_val = $urandom(); end
                4: begin settle_val = 16'd1;    mask_val = $urandom(); end
                default:
                begin
                    settle_val = SETTLE_BITS'($urandom_range(10));
                    mask_val   = $urandom();
                end
            endcase
            if (p == 2)
            begin
                src_idle_pct  = 53;
                sink_idle_pct = 13;
            end
            else if (p == 4)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_reg(REG_SETTLE_TICKS, CFG_DATA_BITS'(settle_val));
            write_reg(REG_INVERT_MASK, mask_val);
            if (p == 1)
            begin
                hold_req = 1'b1;
            end
            tick_span = (settle_val > 8) ? 8 : settle_val;
            random_items(PHASE_ITEMS, tick_span);
        end

        settle_down();
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mid_pkg.sv
rtl/multichannel_input_debouncer_top.sv
rtl/mid_checker.sv
verif/debounce_check.sv
verif/tb.sv
